### rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is held
`define ABD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also runs across reset
`define ABD_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/abd_pkg.sv
// Shared types, constants and coefficient tables for the ADPCM block decoder.
// No dependencies.
package abd_pkg;

  localparam int WordW      = 16;
  localparam int PcmW       = 16;
  localparam int ShiftW     = 4;
  localparam int FiltW      = 3;
  localparam int NibW       = 4;
  localparam int CoefW      = 8;
  localparam int CoefFrac   = 6;
  localparam int NibPerWord = WordW / NibW;
  localparam int NibIdxW    = $clog2(NibPerWord);

  // Widths of the prediction datapath
  localparam int ProdW = PcmW + CoefW;
  localparam int TermW = ProdW - CoefFrac;
  localparam int SumW  = TermW + 2;

  // Queue between front and back
  localparam int QDepth = 2;
  localparam int QAw    = $clog2(QDepth);

  // Item kinds on tuser
  localparam logic CmdHeader = 1'b0;
  localparam logic CmdSample = 1'b1;

  // Large-shift handling
  localparam logic [ShiftW-1:0] ShiftLimit = 4'd12;
  localparam logic [ShiftW-1:0] ShiftLarge = 4'd8;
  localparam logic [WordW-1:0]  SignMask   = 16'h8888;

  // One sample word with the decode settings in force when it arrived
  typedef struct packed {
    logic [WordW-1:0]  word;
    logic [ShiftW-1:0] shift;
    logic [FiltW-1:0]  filter;
  } abd_job_t;

  // Weight on the newer history sample, in 64ths
  function automatic logic signed [CoefW-1:0] coef_pos(input logic [FiltW-1:0] f);
    logic signed [CoefW-1:0] c;
    case (f)
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  // Weight on the older history sample, in 64ths
  function automatic logic signed [CoefW-1:0] coef_neg(input logic [FiltW-1:0] f);
    logic signed [CoefW-1:0] c;
    case (f)
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

### rtl/abd_front.sv
// Front end: accepts input transactions, latches header settings and
// turns sample words into jobs for the queue. Depends on abd_pkg.
module abd_front import abd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [WordW-1:0] in_tdata,  // [15:0] word
  input  logic             in_tuser,  // [0] cmd
  input  logic             q_full,
  output logic             push,
  output abd_job_t         push_job
);

  logic [ShiftW-1:0] shift_r, shift_nxt;
  logic [FiltW-1:0]  filter_r, filter_nxt;
  logic              accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Latch settings from a header transaction
  always_comb begin
    shift_nxt  = shift_r;
    filter_nxt = filter_r;
    if (accept && in_tuser == CmdHeader) begin
      shift_nxt  = in_tdata[ShiftW-1:0];
      filter_nxt = in_tdata[ShiftW +: FiltW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= '0;
      filter_r <= '0;
    end else begin
      shift_r  <= shift_nxt;
      filter_r <= filter_nxt;
    end
  end

  // Build a job: a large shift keeps only the nibble sign bits
  always_comb begin
    push            = accept && in_tuser == CmdSample;
    push_job.filter = filter_r;
    if (shift_r > ShiftLimit) begin
      push_job.word  = in_tdata & SignMask;
      push_job.shift = ShiftLarge;
    end else begin
      push_job.word  = in_tdata;
      push_job.shift = shift_r;
    end
  end

endmodule

### rtl/abd_queue.sv
// Short job queue between front and back, built from registers.
// Depends on abd_pkg.
module abd_queue import abd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  abd_job_t push_job,
  output logic     full,
  output logic     pop_valid,
  input  logic     pop,
  output abd_job_t pop_job
);

  abd_job_t        mem_r [QDepth];
  logic [QAw-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QAw-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QAw:0]    count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = count_r == (QAw+1)'(QDepth);
  assign pop_valid = count_r != '0;
  assign pop_job   = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QAw'(QDepth-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAw'(QDepth-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store payload; no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### rtl/abd_back.sv
// Back end: decodes one nibble per cycle, while the output is not stalled, against the
// two-sample history and drives the output register. Depends on abd_pkg.
module abd_back import abd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  input  abd_job_t        job,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [PcmW-1:0] out_tdata,  // [15:0] pcm
  output logic            out_tlast
);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t                 state_r, state_nxt;
  abd_job_t               job_r;
  logic [NibIdxW-1:0]     idx_r;
  logic signed [PcmW-1:0] hist_new_r, hist_old_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [PcmW-1:0]        out_pcm_r;
  logic                   out_last_r;

  logic                   advance, last_nib;
  logic [NibW-1:0]        nib;
  logic signed [PcmW-1:0] code_s, code_sh;
  logic signed [ProdW-1:0] prod_new, prod_old;
  logic signed [TermW-1:0] term_new, term_old;
  logic signed [SumW-1:0] sum;
  logic [SumW-PcmW:0]     sum_hi;
  logic [PcmW-1:0]        pcm;

  assign advance  = state_r == S_RUN && (!out_valid_r || out_tready);
  assign last_nib = idx_r == NibIdxW'(NibPerWord-1);
  assign pop      = job_valid && (state_r == S_IDLE || (advance && last_nib));

  // Scale the nibble and weight the history
  always_comb begin
    nib      = job_r.word[idx_r*NibW +: NibW];
    code_s   = {nib, {(PcmW-NibW){1'b0}}};
    code_sh  = code_s >>> job_r.shift;
    prod_new = hist_new_r * coef_pos(job_r.filter);
    prod_old = hist_old_r * coef_neg(job_r.filter);
    term_new = prod_new[ProdW-1:CoefFrac];
    term_old = prod_old[ProdW-1:CoefFrac];
    sum      = {{(SumW-PcmW){code_sh[PcmW-1]}}, code_sh}
             + {{(SumW-TermW){term_new[TermW-1]}}, term_new}
             + {{(SumW-TermW){term_old[TermW-1]}}, term_old};
    sum_hi   = sum[SumW-1:PcmW-1];
  end

  // Saturate to 16 bits
  always_comb begin
    if (&sum_hi || ~|sum_hi) begin
      pcm = sum[PcmW-1:0];
    end else if (sum[SumW-1]) begin
      pcm = {1'b1, {(PcmW-1){1'b0}}};
    end else begin
      pcm = {1'b0, {(PcmW-1){1'b1}}};
    end
  end

  // Sequence nibbles and hand jobs over
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (pop) state_nxt = S_RUN;
      end
      S_RUN: begin
        if (advance && last_nib && !pop) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      hist_new_r  <= '0;
      hist_old_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        idx_r <= '0;
      end else if (advance) begin
        idx_r <= idx_r + 1'b1;
      end
      if (advance) begin
        hist_old_r <= hist_new_r;
        hist_new_r <= pcm;
      end
    end
  end

  // Payload registers: job and output sample
  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= job;
    end
    if (advance) begin
      out_pcm_r  <= pcm;
      out_last_r <= last_nib;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pcm_r;
  assign out_tlast  = out_last_r;

endmodule

### rtl/adpcm_block_decoder.sv
// ADPCM block decoder: a header transaction latches shift and filter with no result; a
// sample word gives four samples. The back end gives one sample per cycle while the output
// is not stalled, as it steps through the history chain one nibble at a time.
// Reset (rst_n low, synchronous) clears shift, filter, history, the job queue and the
// output register.
module adpcm_block_decoder import abd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [WordW-1:0] in_tdata,   // [15:0] word
  input  logic             in_tuser,   // [0] cmd
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [PcmW-1:0]  out_tdata,  // [15:0] pcm
  output logic             out_tlast
);

  logic     q_full, push, q_valid, pop;
  abd_job_t push_job, pop_job;

  abd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  abd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (pop),
    .pop_job   (pop_job)
  );

  abd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (q_valid),
    .job        (pop_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/abd_checker.sv
// Port-level checks for the ADPCM block decoder, bound to the top level.
// Depends on abd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module abd_checker import abd_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [PcmW-1:0]  out_tdata,
  input logic             out_tlast
);

  // Stalled output transaction holds
  `ABD_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output changed")

  // Samples of one word follow without a gap once taken
  `ABD_ASSERT(a_word_burst, clk, rst_n, out_tvalid && out_tready && !out_tlast |=> out_tvalid, "gap inside a sample word")

  // Reset empties the output register
  `ABD_ASSERT_RST(a_rst_out, clk, !rst_n |=> !out_tvalid, "output valid after reset")

  // Reset empties the job queue
  `ABD_ASSERT_RST(a_rst_ready, clk, !rst_n |=> in_tready, "input not ready after reset")

endmodule

bind adpcm_block_decoder abd_checker u_abd_checker (.*);
